@@ sv/sacf_pkg.sv @@
// package: shared constants, types and codes for the set-associative tag cache
package sacf_pkg;

   // fixed geometry of the address (sets and line size must be powers of two)
   localparam int unsigned ADDR_W     = 32;
   localparam int unsigned SETS       = 8;
   localparam int unsigned LINE_BYTES = 16;
   localparam int unsigned WAYS_DEF   = 8;
   localparam int unsigned OFFSET_W   = $clog2(LINE_BYTES);
   localparam int unsigned SET_W      = (SETS > 1) ? $clog2(SETS) : 1;
   localparam int unsigned TAG_W      = ADDR_W - OFFSET_W - $clog2(SETS);
   localparam int unsigned WAY_OUT_W  = 3;
   localparam int unsigned CNT_W      = 32;

   // action codes
   localparam logic ACT_ACCESS = 1'b0;
   localparam logic ACT_CLEAR  = 1'b1;

   // controller states
   typedef enum logic {
      ST_IDLE,
      ST_LOOKUP
   } ctrl_state_type;

   // commands from controller to datapath
   typedef struct packed {
      logic capture;
      logic commit;
   } ctrl_cmd_type;

endpackage

@@ sv/sacf_req_if.sv @@
// interface: request channel carrying action and byte address
interface sacf_req_if;
   import sacf_pkg::*;

   logic              valid;
   logic              ready;
   logic              action;
   logic [ADDR_W-1:0] address;

   modport source (output valid, output action, output address, input ready);
   modport sink   (input valid, input action, input address, output ready);
endinterface

@@ sv/sacf_rsp_if.sv @@
// interface: response channel carrying hit, way and both counters
interface sacf_rsp_if;
   import sacf_pkg::*;

   logic                 valid;
   logic                 ready;
   logic                 hit;
   logic [WAY_OUT_W-1:0] way;
   logic [CNT_W-1:0]     hit_count;
   logic [CNT_W-1:0]     miss_count;

   modport source (output valid, output hit, output way, output hit_count,
                   output miss_count, input ready);
   modport sink   (input valid, input hit, input way, input hit_count,
                   input miss_count, output ready);
endinterface

@@ sv/sacf_ram.sv @@
// generic single-write, single-read ram with registered read data
module sacf_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 8,
   localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port, holds when not enabled
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

@@ sv/sacf_ctrl.sv @@
// controller: sequences capture and lookup, owns the response valid flag
module sacf_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   output logic                  out_valid,
   input  logic                  out_ready,
   output sacf_pkg::ctrl_cmd_type cmd
);
   import sacf_pkg::*;

   ctrl_state_type state_ff, state_in;
   logic           out_valid_ff, out_valid_in;
   logic           can_load;

   // output register is free or being emptied this cycle
   assign can_load = !out_valid_ff || out_ready;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (in_valid) begin
               state_in = ST_LOOKUP;
            end
         end
         ST_LOOKUP: begin
            if (can_load) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      in_ready    = 1'b0;
      cmd.capture = 1'b0;
      cmd.commit  = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            in_ready    = 1'b1;
            cmd.capture = in_valid;
         end
         ST_LOOKUP: begin
            cmd.commit = can_load;
         end
         default: begin
            in_ready = 1'b0;
         end
      endcase
   end

   // response valid flag
   always_comb begin
      out_valid_in = out_valid_ff;
      if (cmd.commit) begin
         out_valid_in = 1'b1;
      end else if (out_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   assign out_valid = out_valid_ff;
endmodule

@@ sv/sacf_dpath.sv @@
// datapath: tag ram, valid bits, fifo pointers, counters and response register
module sacf_dpath #(
   parameter int unsigned WAYS = sacf_pkg::WAYS_DEF,
   localparam int unsigned WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1
) (
   input  logic                          clock,
   input  logic                          reset,
   input  sacf_pkg::ctrl_cmd_type        cmd,
   input  logic                          in_action,
   input  logic [sacf_pkg::ADDR_W-1:0]   in_address,
   output logic                          out_hit,
   output logic [sacf_pkg::WAY_OUT_W-1:0] out_way,
   output logic [sacf_pkg::CNT_W-1:0]    out_hit_count,
   output logic [sacf_pkg::CNT_W-1:0]    out_miss_count
);
   import sacf_pkg::*;

   localparam int unsigned ROW_W = WAYS * TAG_W;

   typedef logic [WAYS-1:0][TAG_W-1:0] tag_row_type;

   logic                          action_ff;
   logic [ADDR_W-1:0]             addr_ff;
   logic [SETS-1:0][WAYS-1:0]     valid_ff, valid_in;
   logic [SETS-1:0][WAY_W-1:0]    fifo_ptr_ff, fifo_ptr_in;
   logic [CNT_W-1:0]              hit_cnt_ff, hit_cnt_in;
   logic [CNT_W-1:0]              miss_cnt_ff, miss_cnt_in;
   logic                          out_hit_ff, out_hit_in;
   logic [WAY_OUT_W-1:0]          out_way_ff, out_way_in;
   logic [CNT_W-1:0]              out_hit_cnt_ff, out_hit_cnt_in;
   logic [CNT_W-1:0]              out_miss_cnt_ff, out_miss_cnt_in;

   tag_row_type                   rd_row, wr_row;
   logic [ROW_W-1:0]              rd_data;
   logic [SET_W-1:0]              cur_set;
   logic [TAG_W-1:0]              cur_tag;
   logic [WAYS-1:0]               set_valid;
   logic [WAYS-1:0]               match;
   logic                          hit;
   logic                          set_full;
   logic [WAY_W-1:0]              hit_way, free_way, victim, cur_ptr, next_ptr;
   logic                          ram_we;

   // capture the transaction
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         action_ff <= in_action;
         addr_ff   <= in_address;
      end
   end

   assign cur_set = addr_ff[OFFSET_W +: SET_W];
   assign cur_tag = addr_ff[ADDR_W-1 -: TAG_W];

   // one ram row holds every way's tag of a set
   sacf_ram #(
      .WIDTH (ROW_W),
      .DEPTH (SETS)
   ) u_tag_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (cur_set),
      .wr_data (wr_row),
      .rd_en   (cmd.capture),
      .rd_addr (in_address[OFFSET_W +: SET_W]),
      .rd_data (rd_data)
   );

   assign rd_row = rd_data;

   // tag compare across the set
   assign set_valid = valid_ff[cur_set];
   always_comb begin
      for (int w = 0; w < WAYS; w++) begin
         match[w] = set_valid[w] && (rd_row[w] == cur_tag);
      end
   end

   assign hit      = |match;
   assign set_full = &set_valid;

   // lowest matching way and lowest free way
   always_comb begin
      hit_way  = '0;
      free_way = '0;
      for (int w = WAYS - 1; w >= 0; w--) begin
         if (match[w]) begin
            hit_way = WAY_W'(w);
         end
         if (!set_valid[w]) begin
            free_way = WAY_W'(w);
         end
      end
   end

   // victim choice and fifo pointer advance
   assign cur_ptr  = fifo_ptr_ff[cur_set];
   assign next_ptr = (cur_ptr == WAY_W'(WAYS - 1)) ? '0 : cur_ptr + 1'b1;
   assign victim   = hit ? hit_way : (set_full ? cur_ptr : free_way);

   // write-back row with the victim's tag replaced
   always_comb begin
      for (int w = 0; w < WAYS; w++) begin
         wr_row[w] = (WAY_W'(w) == victim) ? cur_tag : rd_row[w];
      end
   end

   assign ram_we = cmd.commit && (action_ff == ACT_ACCESS) && !hit;

   // state and response update
   always_comb begin
      valid_in        = valid_ff;
      fifo_ptr_in     = fifo_ptr_ff;
      hit_cnt_in      = hit_cnt_ff;
      miss_cnt_in     = miss_cnt_ff;
      out_hit_in      = out_hit_ff;
      out_way_in      = out_way_ff;
      out_hit_cnt_in  = out_hit_cnt_ff;
      out_miss_cnt_in = out_miss_cnt_ff;
      if (cmd.commit) begin
         if (action_ff == ACT_CLEAR) begin
            valid_in        = '0;
            fifo_ptr_in     = '0;
            hit_cnt_in      = '0;
            miss_cnt_in     = '0;
            out_hit_in      = 1'b0;
            out_way_in      = '0;
            out_hit_cnt_in  = '0;
            out_miss_cnt_in = '0;
         end else begin
            if (hit) begin
               if (hit_cnt_ff != '1) begin
                  hit_cnt_in = hit_cnt_ff + 1'b1;
               end
            end else begin
               if (miss_cnt_ff != '1) begin
                  miss_cnt_in = miss_cnt_ff + 1'b1;
               end
               valid_in[cur_set][victim] = 1'b1;
               if (set_full) begin
                  fifo_ptr_in[cur_set] = next_ptr;
               end
            end
            out_hit_in      = hit;
            out_way_in      = WAY_OUT_W'(victim);
            out_hit_cnt_in  = hit_cnt_in;
            out_miss_cnt_in = miss_cnt_in;
         end
      end
   end

   // cache state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         fifo_ptr_ff <= '0;
         hit_cnt_ff  <= '0;
         miss_cnt_ff <= '0;
      end else begin
         valid_ff    <= valid_in;
         fifo_ptr_ff <= fifo_ptr_in;
         hit_cnt_ff  <= hit_cnt_in;
         miss_cnt_ff <= miss_cnt_in;
      end
   end

   // response payload register
   always_ff @(posedge clock) begin
      out_hit_ff      <= out_hit_in;
      out_way_ff      <= out_way_in;
      out_hit_cnt_ff  <= out_hit_cnt_in;
      out_miss_cnt_ff <= out_miss_cnt_in;
   end

   assign out_hit        = out_hit_ff;
   assign out_way        = out_way_ff;
   assign out_hit_count  = out_hit_cnt_ff;
   assign out_miss_count = out_miss_cnt_ff;
endmodule

@@ sv/set_assoc_cache_fifo_tags_top.sv @@
// top level: set-associative tag cache with fifo replacement
//
//   channel  direction  carries
//   req      in         action, address
//   rsp      out        hit, way, hit_count, miss_count
//
// in each transaction the set's tag row is read from the tag ram in the accept
// cycle, then compared and, on a miss, written back in the lookup state
// the response register lets a new request be accepted while a response waits;
// a lookup stalls in the lookup state until that register is free
// synchronous reset clears valid bits, fifo pointers and counters at once;
// the tag ram itself is not cleared
module set_assoc_cache_fifo_tags_top #(
   parameter int unsigned WAYS = sacf_pkg::WAYS_DEF
) (
   input logic        clock,
   input logic        reset,
   sacf_req_if.sink   req_bus,
   sacf_rsp_if.source rsp_bus
);
   import sacf_pkg::*;

   ctrl_cmd_type cmd;

   // sequencing
   sacf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_bus.valid),
      .in_ready  (req_bus.ready),
      .out_valid (rsp_bus.valid),
      .out_ready (rsp_bus.ready),
      .cmd       (cmd)
   );

   // lookup, replacement and counters
   sacf_dpath #(
      .WAYS (WAYS)
   ) u_dpath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .in_action      (req_bus.action),
      .in_address     (req_bus.address),
      .out_hit        (rsp_bus.hit),
      .out_way        (rsp_bus.way),
      .out_hit_count  (rsp_bus.hit_count),
      .out_miss_count (rsp_bus.miss_count)
   );
endmodule

@@ sv/sacf_chk.sv @@
// checker: port-level properties of the tag cache, bound to the top level
module sacf_chk (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_valid,
   input logic                             req_ready,
   input logic                             rsp_valid,
   input logic                             rsp_ready,
   input logic                             rsp_hit,
   input logic [sacf_pkg::WAY_OUT_W-1:0]   rsp_way,
   input logic [sacf_pkg::CNT_W-1:0]       rsp_hit_count,
   input logic [sacf_pkg::CNT_W-1:0]       rsp_miss_count
);
   import sacf_pkg::*;

   // a stalled response holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_hit) && $stable(rsp_way)
         && $stable(rsp_hit_count) && $stable(rsp_miss_count))
      else $error("response changed while stalled");

   // one transaction in flight: no accept in the cycle after an accept
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request accepted during lookup");

   // a fresh response follows an accepted request and its lookup state
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && req_ready, 2))
      else $error("response without request");

   // a hit response always shows a nonzero hit count
   a_hit_counted: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_hit |-> rsp_hit_count != '0)
      else $error("hit reported with zero hit count");
endmodule

bind set_assoc_cache_fifo_tags_top sacf_chk u_sacf_chk (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_bus.valid),
   .req_ready      (req_bus.ready),
   .rsp_valid      (rsp_bus.valid),
   .rsp_ready      (rsp_bus.ready),
   .rsp_hit        (rsp_bus.hit),
   .rsp_way        (rsp_bus.way),
   .rsp_hit_count  (rsp_bus.hit_count),
   .rsp_miss_count (rsp_bus.miss_count)
);

@@ tb/set_assoc_cache_fifo_tags_top_tb.sv @@
// testbench: set-associative tag cache with fifo replacement, checked against its own model
module set_assoc_cache_fifo_tags_top_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import sacf_pkg::*;

   localparam int unsigned WAYS            = WAYS_DEF;
   localparam int unsigned TAG_POOL        = 12;
   localparam int unsigned IDLE_PCT        = 7;
   localparam int unsigned RSP_HOLD_CYCLES = 200;
   localparam int unsigned QUIET_LIMIT     = 2000;
   localparam int unsigned DRAIN_CYCLES    = 8;

   typedef struct packed {
      logic                 hit;
      logic [WAY_OUT_W-1:0] way;
      logic [CNT_W-1:0]     hit_count;
      logic [CNT_W-1:0]     miss_count;
   } cache_result_type;

   logic clock = 1'b0;
   logic reset;

   sacf_req_if req_bus ();
   sacf_rsp_if rsp_bus ();

   set_assoc_cache_fifo_tags_top #(
      .WAYS(WAYS)
   ) dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   // model state: tags, valid bits, fifo pointers and counters
   logic [TAG_W-1:0]     line_tag   [SETS][WAYS];
   logic                 line_valid [SETS][WAYS];
   logic [WAY_OUT_W-1:0] fifo_ptr   [SETS];
   logic [CNT_W-1:0]     hits_seen;
   logic [CNT_W-1:0]     misses_seen;

   cache_result_type     awaited_results [$];
   cache_result_type     next_expected;
   logic [TAG_W-1:0]     tag_pool [TAG_POOL];
   int unsigned          error_count  = 0;
   int unsigned          quiet_cycles = 0;
   int unsigned          hold_reqs    = 0;
   int unsigned          holds_done   = 0;
   bit                   gaps_on      = 1'b1;

   // clock
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // invalidate every way, zero the pointers and both counters
   function automatic void clear_cache_model();
      for (int s = 0; s < SETS; s++) begin
         fifo_ptr[s] = '0;
         for (int w = 0; w < WAYS; w++) line_valid[s][w] = 1'b0;
      end
      hits_seen   = '0;
      misses_seen = '0;
   endfunction

   // one transaction on the model: clear, hit search, fill of an invalid way, or fifo eviction
   function automatic cache_result_type predict_lookup(input logic              action,
                                                       input logic [ADDR_W-1:0] address);
      cache_result_type res;
      int unsigned      set_idx;
      logic [TAG_W-1:0] tag;
      int unsigned      chosen;
      bit               hit;
      bit               placed;
      res = '0;
      if (action == ACT_CLEAR) begin
         clear_cache_model();
         return res;
      end
      set_idx = address[OFFSET_W +: SET_W];
      tag     = address[ADDR_W-1 -: TAG_W];
      hit     = 1'b0;
      placed  = 1'b0;
      chosen  = 0;
      // lowest valid way holding the tag
      for (int w = 0; w < WAYS; w++) begin
         if (!hit && line_valid[set_idx][w] && line_tag[set_idx][w] == tag) begin
            hit    = 1'b1;
            chosen = w;
         end
      end
      if (hit) begin
         if (hits_seen != '1) hits_seen++;
      end else begin
         // lowest invalid way first, otherwise the way under the fifo pointer
         for (int w = 0; w < WAYS; w++) begin
            if (!placed && !line_valid[set_idx][w]) begin
               placed = 1'b1;
               chosen = w;
            end
         end
         if (!placed) begin
            chosen            = fifo_ptr[set_idx] % WAYS;
            fifo_ptr[set_idx] = WAY_OUT_W'((chosen + 1) % WAYS);
         end
         line_tag[set_idx][chosen]   = tag;
         line_valid[set_idx][chosen] = 1'b1;
         if (misses_seen != '1) misses_seen++;
      end
      res.hit        = hit;
      res.way        = WAY_OUT_W'(chosen);
      res.hit_count  = hits_seen;
      res.miss_count = misses_seen;
      return res;
   endfunction

   function automatic logic [ADDR_W-1:0] line_addr(input logic [TAG_W-1:0]    tag,
                                                   input logic [SET_W-1:0]    set_idx,
                                                   input logic [OFFSET_W-1:0] offset);
      return {tag, set_idx, offset};
   endfunction

   function automatic void fill_tag_pool();
      for (int i = 0; i < TAG_POOL; i++) tag_pool[i] = TAG_W'($urandom());
   endfunction

   function automatic void check_field(input string           field,
                                       input logic [CNT_W-1:0] expected,
                                       input logic [CNT_W-1:0] actual);
      if (actual !== expected) begin
         $display("%0t: %s mismatch: expected 0x%0h, actual 0x%0h",
                  $time, field, expected, actual);
         error_count++;
      end
   endfunction

   // offer one transaction, wait for acceptance, then record its expected result
   task automatic send_lookup(input logic action, input logic [ADDR_W-1:0] address);
      while (gaps_on && $urandom_range(99) < IDLE_PCT) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid   <= 1'b1;
      req_bus.action  <= action;
      req_bus.address <= address;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      awaited_results.push_back(predict_lookup(action, address));
   endtask

   // mostly pooled tags so sets fill and evict, some raw addresses, rare clears
   task automatic send_random_lookup();
      int unsigned pick;
      pick = $urandom_range(999);
      if (pick < 5)
         send_lookup(ACT_CLEAR, $urandom());
      else if (pick < 105)
         send_lookup(ACT_ACCESS, $urandom());
      else
         send_lookup(ACT_ACCESS, line_addr(tag_pool[$urandom_range(TAG_POOL-1)],
                                           SET_W'($urandom_range(SETS-1)),
                                           OFFSET_W'($urandom_range(LINE_BYTES-1))));
   endtask

   task automatic test_directed_cases();
      // cold miss, same-line hit, all-ones address
      send_lookup(ACT_ACCESS, '0);
      send_lookup(ACT_ACCESS, 32'h0000_000F);
      send_lookup(ACT_ACCESS, '1);
      send_lookup(ACT_ACCESS, 32'hFFFF_FFF0);
      // fill set 3, then two evictions through the fifo pointer
      for (int k = 1; k <= WAYS + 2; k++)
         send_lookup(ACT_ACCESS, line_addr(TAG_W'(k), 3'd3, '0));
      // hit leaves the pointer alone, evicted tag misses into the next victim
      send_lookup(ACT_ACCESS, line_addr(TAG_W'(5), 3'd3, '1));
      send_lookup(ACT_ACCESS, line_addr(TAG_W'(1), 3'd3, '0));
      // clear drops every line and both counters
      send_lookup(ACT_CLEAR, '0);
      send_lookup(ACT_ACCESS, '0);
      send_lookup(ACT_CLEAR, '1);
      send_lookup(ACT_ACCESS, line_addr(TAG_W'(5), 3'd3, '0));
   endtask

   task automatic test_back_to_back();
      gaps_on = 1'b0;
      fill_tag_pool();
      repeat (300) send_random_lookup();
      gaps_on = 1'b1;
   endtask

   task automatic test_response_stall();
      hold_reqs++;
      repeat (40) send_random_lookup();
   endtask

   task automatic test_random_traffic();
      for (int i = 0; i < 1290; i++) begin
         if (i % 300 == 0) fill_tag_pool();
         send_random_lookup();
      end
   endtask

   // response ready: random gaps, or a long counted hold when asked
   initial begin
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_reqs != holds_done) begin
            rsp_bus.ready <= 1'b0;
            repeat (RSP_HOLD_CYCLES) @(posedge clock);
            holds_done++;
         end else if (gaps_on && $urandom_range(99) < IDLE_PCT) begin
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   // compare each response transaction with the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (awaited_results.size() == 0) begin
            $display("%0t: unexpected response: expected none, actual hit %0b way %0d",
                     $time, rsp_bus.hit, rsp_bus.way);
            error_count++;
         end else begin
            next_expected = awaited_results.pop_front();
            check_field("hit", CNT_W'(next_expected.hit), CNT_W'(rsp_bus.hit));
            check_field("way", CNT_W'(next_expected.way), CNT_W'(rsp_bus.way));
            check_field("hit_count", next_expected.hit_count, rsp_bus.hit_count);
            check_field("miss_count", next_expected.miss_count, rsp_bus.miss_count);
         end
      end
   end

   // watchdog on cycles with no transaction on either channel
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("%0t: timeout, %0d responses outstanding", $time, awaited_results.size());
         $display("set_assoc_cache_fifo_tags_top_tb: FAIL");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // reset, tests in turn, drain and verdict
   initial begin
      reset           <= 1'b1;
      req_bus.valid   <= 1'b0;
      req_bus.action  <= ACT_ACCESS;
      req_bus.address <= '0;
      clear_cache_model();
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      test_directed_cases();
      test_back_to_back();
      test_response_stall();
      test_random_traffic();

      req_bus.valid <= 1'b0;
      while (awaited_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0)
         $display("set_assoc_cache_fifo_tags_top_tb: PASS");
      else
         $display("set_assoc_cache_fifo_tags_top_tb: FAIL");
      $finish;
   end

endmodule
